/* rtl/save_type_signature_scanner_assert.svh */
// Assertion macros for the save-type signature scanner RTL.
`ifndef SAVE_TYPE_SIGNATURE_SCANNER_ASSERT_SVH
`define SAVE_TYPE_SIGNATURE_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sts_pkg.sv */
// Package: types, signature table and defaults for the save-type scanner.
`timescale 1ns / 1ps
package sts_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned OFF_W       = 25;
  localparam int unsigned SIG_COUNT   = 6;
  localparam int unsigned SIG_MAX_LEN = 10;
  localparam int unsigned WIN_W       = SIG_MAX_LEN * DATA_W;
  localparam int unsigned LEN_W       = $clog2(SIG_MAX_LEN + 1);

  localparam int unsigned MAX_IMAGE_BYTES_DEF = 33554432;
  localparam int unsigned START_ALIGN_DEF     = 4;

  typedef enum logic [2:0] {
    SAVE_NONE     = 3'd0,
    SAVE_EEPROM   = 3'd1,
    SAVE_SRAM     = 3'd2,
    SAVE_FLASH64  = 3'd3,
    SAVE_FLASH128 = 3'd4
  } save_type_t;

  // Text is right-justified: byte j of the word is character (len-1-j),
  // which lines up with window byte j (byte 0 is the newest).
  // ASCII codes in table order: eeprom, sram (short), sram (long),
  // flash (short), flash 512, flash 1M.
  localparam logic [WIN_W-1:0] SIG_TEXT [SIG_COUNT] = '{
    WIN_W'(64'h45455052_4F4D5F56),
    WIN_W'(48'h5352414D_5F56),
    WIN_W'(64'h5352414D_5F465F56),
    WIN_W'(56'h464C4153_485F56),
    WIN_W'(80'h464C4153_4835_31325F56),
    WIN_W'(72'h464C4153_48314D5F56)
  };

  localparam int unsigned SIG_LEN [SIG_COUNT] = '{8, 6, 8, 7, 10, 9};

  localparam save_type_t SIG_CODE [SIG_COUNT] = '{
    SAVE_EEPROM, SAVE_SRAM, SAVE_SRAM, SAVE_FLASH64, SAVE_FLASH64, SAVE_FLASH128
  };

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
  } sts_item_t;

  typedef struct packed {
    logic             valid;
    save_type_t       save_type;
    logic [OFF_W-1:0] match_offset;
  } sts_result_t;

  // Byte mask covering the low len bytes of the window.
  function automatic logic [WIN_W-1:0] sig_mask(input int unsigned len);
    logic [WIN_W-1:0] m;
    m = '0;
    for (int k = 0; k < SIG_MAX_LEN; k++) begin
      if (k < len) m[k*DATA_W +: DATA_W] = {DATA_W{1'b1}};
    end
    return m;
  endfunction

endpackage

/* rtl/save_type_signature_scanner.sv */
// Top level of the cartridge save-type signature scanner.
//
//   channel | direction | ports                                 | transfer when
//   --------+-----------+---------------------------------------+---------------------
//   in      | input     | in_data_byte[7:0], in_last_byte       | in_valid & !in_stall
//   out     | output    | out_save_type[2:0], out_match_offset  | out_valid & !out_stall
//
// Throughput: one byte per cycle while in_stall is low; the six signature compares
//   run in parallel on the byte window in a single pass between the input and
//   result registers; a final byte's result passes through both to reach out_valid.
// Reset: synchronous, active low; no clearing pass, ready right after reset.
// Stalls: in_stall rises only while a final byte waits behind a held result.
`timescale 1ns / 1ps
module save_type_signature_scanner #(
  parameter int unsigned MAX_IMAGE_BYTES = sts_pkg::MAX_IMAGE_BYTES_DEF,
  parameter int unsigned START_ALIGN     = sts_pkg::START_ALIGN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_save_type,
  output logic [24:0] out_match_offset
);
  import sts_pkg::*;

  sts_item_t   item;
  sts_result_t res;
  logic        go;
  logic        step;

  // A non-final byte never produces a result, so it always proceeds.
  // A final byte waits only if the result register is full and held.
  assign go       = !(item.last_byte && out_valid && out_stall);
  assign step     = item.valid && go;
  assign in_stall = item.valid && !go;

  sts_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .hold         (in_stall),
    .item         (item)
  );

  sts_scan_core #(
    .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES),
    .START_ALIGN     (START_ALIGN)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .step  (step),
    .res   (res)
  );

  sts_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_save_type    (out_save_type),
    .out_match_offset (out_match_offset)
  );

endmodule

/* rtl/sts_in_reg.sv */
// Input register stage of the save-type scanner.
`timescale 1ns / 1ps
module sts_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic              hold,
  output sts_pkg::sts_item_t item
);
  import sts_pkg::*;

  sts_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.valid <= 1'b0;
    end else if (!hold) begin
      item_r.valid <= in_valid;
    end
    if (!hold) begin
      item_r.data_byte <= in_data_byte;
      item_r.last_byte <= in_last_byte;
    end
  end

  assign item = item_r;

endmodule

/* rtl/sts_scan_core.sv */
// Window, position tracking, signature compare and best-match selection.
`timescale 1ns / 1ps
`include "save_type_signature_scanner_assert.svh"
module sts_scan_core #(
  parameter int unsigned MAX_IMAGE_BYTES = sts_pkg::MAX_IMAGE_BYTES_DEF,
  parameter int unsigned START_ALIGN     = sts_pkg::START_ALIGN_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sts_pkg::sts_item_t  item,
  input  logic                step,
  output sts_pkg::sts_result_t res
);
  import sts_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_IMAGE_BYTES + 1);
  localparam int unsigned PH_W  = (START_ALIGN > 1) ? $clog2(START_ALIGN) : 1;

  logic [WIN_W-1:0] win_r;
  logic [POS_W-1:0] pos_r;
  logic [PH_W-1:0]  ph_r;
  save_type_t       best_type_r;
  logic [OFF_W-1:0] best_start_r;

  logic [WIN_W-1:0] win_nxt;
  logic [POS_W-1:0] count;
  logic [PH_W-1:0]  ph_nxt;
  logic             active;
  logic [SIG_COUNT-1:0] hit;

  logic             sel_found;
  logic [LEN_W-1:0] sel_len;
  save_type_t       sel_code;
  logic [OFF_W-1:0] sel_start;
  logic             upd;
  save_type_t       best_type_nxt;
  logic [OFF_W-1:0] best_start_nxt;

  // Saturated position: bytes past the limit are ignored for matching.
  assign active  = pos_r < POS_W'(MAX_IMAGE_BYTES);
  assign win_nxt = {win_r[WIN_W-DATA_W-1:0], item.data_byte};
  assign count   = pos_r + POS_W'(1);
  // count modulo START_ALIGN, tracked incrementally
  assign ph_nxt  = (ph_r == PH_W'(START_ALIGN - 1)) ? '0 : ph_r + PH_W'(1);

  for (genvar g = 0; g < SIG_COUNT; g++) begin : g_sig
    localparam int unsigned LEN     = SIG_LEN[g];
    localparam int unsigned LEN_MOD = LEN % START_ALIGN;
    localparam logic [WIN_W-1:0] MASK = sig_mask(LEN);
    assign hit[g] = (count >= POS_W'(LEN)) && (ph_nxt == PH_W'(LEN_MOD)) &&
                    (((win_nxt ^ SIG_TEXT[g]) & MASK) == '0);
  end

  // All hits this byte end here: longest one starts earliest; table order on ties.
  always_comb begin
    sel_found = 1'b0;
    sel_len   = '0;
    sel_code  = SAVE_NONE;
    for (int i = 0; i < SIG_COUNT; i++) begin
      if (hit[i] && (!sel_found || LEN_W'(SIG_LEN[i]) > sel_len)) begin
        sel_found = 1'b1;
        sel_len   = LEN_W'(SIG_LEN[i]);
        sel_code  = SIG_CODE[i];
      end
    end
  end

  assign sel_start = OFF_W'(count - POS_W'(sel_len));
  assign upd = active && sel_found &&
               ((best_type_r == SAVE_NONE) || (sel_start < best_start_r));
  assign best_type_nxt  = upd ? sel_code : best_type_r;
  assign best_start_nxt = upd ? sel_start : best_start_r;

  assign res.valid        = step && item.last_byte;
  assign res.save_type    = best_type_nxt;
  assign res.match_offset = (best_type_nxt != SAVE_NONE) ? best_start_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      ph_r         <= '0;
      best_type_r  <= SAVE_NONE;
      best_start_r <= '0;
    end else if (step) begin
      if (item.last_byte) begin
        pos_r        <= '0;
        ph_r         <= '0;
        best_type_r  <= SAVE_NONE;
        best_start_r <= '0;
      end else if (active) begin
        pos_r        <= count;
        ph_r         <= ph_nxt;
        best_type_r  <= best_type_nxt;
        best_start_r <= best_start_nxt;
      end
    end
  end

  // window bytes are only compared once count covers them
  always_ff @(posedge clk) begin
    if (step && active) win_r <= win_nxt;
  end

  `STS_ASSERT_IMP(a_pos_limit, clk, rst_n, 1'b1, pos_r <= POS_W'(MAX_IMAGE_BYTES), "position past limit")
  `STS_ASSERT_IMP(a_best_before_pos, clk, rst_n, best_type_r != SAVE_NONE, POS_W'(best_start_r) < pos_r, "best start not before position")
  `STS_ASSERT_NXT(a_clear_on_last, clk, rst_n, step && item.last_byte, pos_r == '0 && best_type_r == SAVE_NONE, "state not cleared after final byte")
  `STS_ASSERT_IMP(a_none_zero_off, clk, rst_n, res.valid && res.save_type == SAVE_NONE, res.match_offset == '0, "nonzero offset with no match")

endmodule

/* rtl/sts_out_reg.sv */
// Result register stage of the save-type scanner.
`timescale 1ns / 1ps
module sts_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sts_pkg::sts_result_t res,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [2:0]           out_save_type,
  output logic [24:0]          out_match_offset
);
  import sts_pkg::*;

  logic             valid_r;
  save_type_t       type_r;
  logic [OFF_W-1:0] off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.valid) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
    if (res.valid) begin
      type_r <= res.save_type;
      off_r  <= res.match_offset;
    end
  end

  assign out_valid        = valid_r;
  assign out_save_type    = 3'(type_r);
  assign out_match_offset = off_r;

endmodule
